/* sv/rsw_pkg.sv */
// rsw_pkg: shared types and constants for the receive sequence window.
// Used by receive_sequence_window; no dependencies.
package rsw_pkg;

    localparam int SEQ_W            = 31;
    localparam int WSIZE_W          = 11;
    localparam int ADV_W            = 11;
    localparam int STATUS_W         = 3;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;
    localparam int WINDOW_DEPTH_DEF = 1024;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_INIT_SEQ = 1'b0;
    localparam logic REG_WIN_SIZE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OLDER   = 3'd0,
        ST_BEYOND  = 3'd1,
        ST_DUP     = 3'd2,
        ST_INORDER = 3'd3,
        ST_OOO     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CLASS,
        S_CHECK,
        S_WALK_RD,
        S_WALK_CHK,
        S_RESULT
    } t_state;

endpackage

/* sv/rsw_mark_ram.sv */
// rsw_mark_ram: single-port one-bit mark memory, registered read.
// Depends on nothing; depth handed down from receive_sequence_window.
module rsw_mark_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic          i_re,
    input  logic [AW-1:0] i_addr,
    input  logic          i_wdata,
    output logic          o_rdata
);

    logic mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/receive_sequence_window.sv */
// receive_sequence_window: sliding receive window over 31-bit sequence numbers.
// Depends on rsw_pkg and rsw_mark_ram.
//
// Input channel (i_in_valid/o_in_ready) takes one sequence number per
// transfer; output channel (o_out_valid/i_out_ready) returns one result per
// input: status, gap range for out-of-order packets, window advance for
// in-order packets. One item is processed at a time.
// Older/beyond items are classified without a mark read; duplicate,
// out-of-order and in-order items read their mark first. In-order items then
// walk the window, reading and clearing marks in turn on the single memory port.
// o_in_ready returns when the result is placed in the output register, even if
// that result is still stalled. If the receiver stalls, the finished result waits
// in the output register and the block holds the next result until it drains.
// Reset and any APB write clear the mark memory with o_in_ready low; then the
// window restarts at head 0 with the expected number taken from initial_sequence.
// APB: initial_sequence at 0x0, window_size at 0x4; pready is always high.
module receive_sequence_window #(
    parameter int WINDOW_DEPTH = rsw_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rsw_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [rsw_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rsw_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [rsw_pkg::SEQ_W-1:0]          i_sequence_req,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [rsw_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_gap_valid,
    output logic [rsw_pkg::SEQ_W-1:0]          o_gap_first,
    output logic [rsw_pkg::SEQ_W-1:0]          o_gap_last,
    output logic [rsw_pkg::ADV_W-1:0]          o_advance
);

    localparam int AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SZW = AW + 1;
    localparam int SW  = rsw_pkg::SEQ_W;

    rsw_pkg::t_state  r_state, n_state;
    logic [AW-1:0]    r_clr_cnt, n_clr_cnt;
    logic [SW-1:0]    r_init, n_init;
    logic [rsw_pkg::WSIZE_W-1:0] r_wsize, n_wsize;
    logic [AW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_exp, n_exp;
    logic [SW-1:0]    r_seq, n_seq;
    logic [SW-1:0]    r_dist, n_dist;
    logic [AW-1:0]    r_slot, n_slot;
    logic [SZW-1:0]   r_adv, n_adv;
    rsw_pkg::t_status r_res_status, n_res_status;
    logic             r_res_gap, n_res_gap;
    logic [SW-1:0]    r_res_first, n_res_first;
    logic [SW-1:0]    r_res_last, n_res_last;

    logic             r_out_valid, n_out_valid;
    rsw_pkg::t_status r_out_status, n_out_status;
    logic             r_out_gap, n_out_gap;
    logic [SW-1:0]    r_out_first, n_out_first;
    logic [SW-1:0]    r_out_last, n_out_last;
    logic [SZW-1:0]   r_out_adv, n_out_adv;

    logic             cfg_we;
    logic [SZW-1:0]   size;
    logic [SZW-1:0]   slot_sum;
    logic [AW-1:0]    slot_addr;
    logic [SZW-1:0]   head_p1;
    logic [AW-1:0]    head_next;
    logic [SZW-1:0]   adv_p1;

    logic             ram_we;
    logic             ram_re;
    logic [AW-1:0]    ram_addr;
    logic             ram_wdata;
    logic             ram_rdata;

    rsw_mark_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // APB
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            if (paddr[2] == rsw_pkg::REG_INIT_SEQ) begin
                prdata = {{(rsw_pkg::APB_DATA_W-SW){1'b0}}, r_init};
            end else begin
                prdata = {{(rsw_pkg::APB_DATA_W-rsw_pkg::WSIZE_W){1'b0}}, r_wsize};
            end
        end
    end

    // effective window size
    always_comb begin
        if (r_wsize == '0) begin
            size = SZW'(1);
        end else if (32'(r_wsize) > WINDOW_DEPTH) begin
            size = SZW'(WINDOW_DEPTH);
        end else begin
            size = SZW'(r_wsize);
        end
    end

    assign slot_sum  = {1'b0, r_head} + SZW'(r_dist);
    assign slot_addr = (slot_sum >= size) ? AW'(slot_sum - size) : AW'(slot_sum);
    assign head_p1   = {1'b0, r_head} + SZW'(1);
    assign head_next = (head_p1 == size) ? '0 : AW'(head_p1);
    assign adv_p1    = r_adv + SZW'(1);

    assign o_in_ready = (r_state == rsw_pkg::S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_init       = r_init;
        n_wsize      = r_wsize;
        n_head       = r_head;
        n_exp        = r_exp;
        n_seq        = r_seq;
        n_dist       = r_dist;
        n_slot       = r_slot;
        n_adv        = r_adv;
        n_res_status = r_res_status;
        n_res_gap    = r_res_gap;
        n_res_first  = r_res_first;
        n_res_last   = r_res_last;
        n_out_valid  = r_out_valid & ~i_out_ready;
        n_out_status = r_out_status;
        n_out_gap    = r_out_gap;
        n_out_first  = r_out_first;
        n_out_last   = r_out_last;
        n_out_adv    = r_out_adv;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_addr     = r_head;
        ram_wdata    = 1'b0;

        case (r_state)
            rsw_pkg::S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_clr_cnt;
                if (r_clr_cnt == AW'(WINDOW_DEPTH - 1)) begin
                    n_state = rsw_pkg::S_IDLE;
                end else begin
                    n_clr_cnt = r_clr_cnt + AW'(1);
                end
            end
            rsw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_seq   = i_sequence_req;
                    n_dist  = i_sequence_req - r_exp;
                    n_state = rsw_pkg::S_CLASS;
                end
            end
            rsw_pkg::S_CLASS: begin
                n_res_gap   = 1'b0;
                n_res_first = '0;
                n_res_last  = '0;
                n_adv       = '0;
                if (r_dist[SW-1]) begin
                    n_res_status = rsw_pkg::ST_OLDER;
                    n_state      = rsw_pkg::S_RESULT;
                end else if (r_dist >= SW'(size)) begin
                    n_res_status = rsw_pkg::ST_BEYOND;
                    n_state      = rsw_pkg::S_RESULT;
                end else begin
                    ram_re   = 1'b1;
                    ram_addr = slot_addr;
                    n_slot   = slot_addr;
                    n_state  = rsw_pkg::S_CHECK;
                end
            end
            rsw_pkg::S_CHECK: begin
                if (ram_rdata) begin
                    n_res_status = rsw_pkg::ST_DUP;
                    n_state      = rsw_pkg::S_RESULT;
                end else if (r_dist != '0) begin
                    ram_we       = 1'b1;
                    ram_addr     = r_slot;
                    ram_wdata    = 1'b1;
                    n_res_status = rsw_pkg::ST_OOO;
                    n_res_gap    = 1'b1;
                    n_res_first  = r_exp;
                    n_res_last   = r_seq - SW'(1);
                    n_state      = rsw_pkg::S_RESULT;
                end else begin
                    // in order: the new mark is at head and is consumed at once
                    ram_we       = 1'b1;
                    ram_addr     = r_head;
                    n_head       = head_next;
                    n_exp        = r_exp + SW'(1);
                    n_adv        = SZW'(1);
                    n_res_status = rsw_pkg::ST_INORDER;
                    n_state      = (size == SZW'(1)) ? rsw_pkg::S_RESULT
                                                     : rsw_pkg::S_WALK_RD;
                end
            end
            rsw_pkg::S_WALK_RD: begin
                ram_re   = 1'b1;
                ram_addr = r_head;
                n_state  = rsw_pkg::S_WALK_CHK;
            end
            rsw_pkg::S_WALK_CHK: begin
                if (ram_rdata) begin
                    ram_we   = 1'b1;
                    ram_addr = r_head;
                    n_head   = head_next;
                    n_exp    = r_exp + SW'(1);
                    n_adv    = adv_p1;
                    n_state  = (adv_p1 == size) ? rsw_pkg::S_RESULT
                                                : rsw_pkg::S_WALK_RD;
                end else begin
                    n_state = rsw_pkg::S_RESULT;
                end
            end
            rsw_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_gap    = r_res_gap;
                    n_out_first  = r_res_first;
                    n_out_last   = r_res_last;
                    n_out_adv    = r_adv;
                    n_state      = rsw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rsw_pkg::S_CLEAR;
            end
        endcase

        // any register write restarts the window
        if (cfg_we) begin
            if (paddr[2] == rsw_pkg::REG_INIT_SEQ) begin
                n_init = pwdata[SW-1:0];
            end else begin
                n_wsize = pwdata[rsw_pkg::WSIZE_W-1:0];
            end
            n_state   = rsw_pkg::S_CLEAR;
            n_clr_cnt = '0;
            n_head    = '0;
            n_exp     = n_init;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rsw_pkg::S_CLEAR;
            r_clr_cnt   <= '0;
            r_init      <= '0;
            r_wsize     <= rsw_pkg::WSIZE_RESET;
            r_head      <= '0;
            r_exp       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_init      <= n_init;
            r_wsize     <= n_wsize;
            r_head      <= n_head;
            r_exp       <= n_exp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seq        <= n_seq;
        r_dist       <= n_dist;
        r_slot       <= n_slot;
        r_adv        <= n_adv;
        r_res_status <= n_res_status;
        r_res_gap    <= n_res_gap;
        r_res_first  <= n_res_first;
        r_res_last   <= n_res_last;
        r_out_status <= n_out_status;
        r_out_gap    <= n_out_gap;
        r_out_first  <= n_out_first;
        r_out_last   <= n_out_last;
        r_out_adv    <= n_out_adv;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_gap_valid = r_out_gap;
    assign o_gap_first = r_out_first;
    assign o_gap_last  = r_out_last;
    assign o_advance   = rsw_pkg::ADV_W'(r_out_adv);

endmodule
